### hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU store
// Item types, controller/datapath command and status, sizing constants.
// ----------------------------------------------------------------------------
package lfu_pkg;

   // sizing
   localparam int ENTRIES    = 16;
   localparam int IDX_BITS   = 4;
   localparam int RANK_BITS  = 4;
   localparam int COUNT_BITS = 16;
   localparam int CAP_BITS   = 5;
   localparam int KEY_BITS   = 32;
   localparam int DATA_BITS  = 32;

   localparam logic [CAP_BITS-1:0]   CAP_RESET = 5'd16;
   localparam logic [CAP_BITS-1:0]   CAP_MAX   = 5'd16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
   localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(ENTRIES - 1);

   // request kinds
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] read_value;
      logic                 evicted;
      logic [KEY_BITS-1:0]  evicted_key;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

### hdl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl: sequencer for the LFU store
// Accepts an item, steps the entry scan, then commits the update and result.
// ----------------------------------------------------------------------------
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new item
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid holds until taken
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // an accepted item starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   // scan ends on the last entry
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_last) |=> (state_ff == ST_COMMIT))
      else $error("scan did not end in commit");

   // a new result only comes out of commit
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result raised outside commit");
`endif

endmodule

### hdl/lfu_dpath.sv
// ----------------------------------------------------------------------------
// lfu_dpath: entry store, scan trackers and update logic
// One entry is examined per scan step; the commit updates all entries at once.
// ----------------------------------------------------------------------------
module lfu_dpath
   import lfu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  req_type             req_data,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata
);

   // entry store
   logic                  valid_ff [ENTRIES];
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [DATA_BITS-1:0]  data_ff  [ENTRIES];
   logic [COUNT_BITS-1:0] count_ff [ENTRIES];
   logic [RANK_BITS-1:0]  rank_ff  [ENTRIES];
   logic [CAP_BITS-1:0]   occ_ff;
   logic [CAP_BITS-1:0]   cap_ff;

   // request and scan trackers
   req_type               req_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic                  found_ff;
   logic [IDX_BITS-1:0]   found_idx_ff;
   logic [DATA_BITS-1:0]  found_data_ff;
   logic [RANK_BITS-1:0]  found_rank_ff;
   logic                  any_ff;
   logic [IDX_BITS-1:0]   vic_idx_ff;
   logic [KEY_BITS-1:0]   vic_key_ff;
   logic [COUNT_BITS-1:0] vic_count_ff;
   logic [RANK_BITS-1:0]  vic_rank_ff;
   logic                  free_ff;
   logic [IDX_BITS-1:0]   free_idx_ff;
   rsp_type               rsp_ff;

   logic                  cur_valid, cur_match, cur_better;
   logic [CAP_BITS-1:0]   cap_eff;
   logic                  is_put, do_hit, do_evict, do_fill;
   logic [IDX_BITS-1:0]   slot;

   assign status.scan_last = (idx_ff == IDX_LAST);

   // current scan entry
   assign cur_valid  = valid_ff[idx_ff];
   assign cur_match  = cur_valid && (key_ff[idx_ff] == req_ff.key);
   assign cur_better = cur_valid &&
      (!any_ff || (count_ff[idx_ff] < vic_count_ff) ||
       ((count_ff[idx_ff] == vic_count_ff) && (rank_ff[idx_ff] > vic_rank_ff)));

   // commit decisions
   assign cap_eff  = (cap_ff > CAP_MAX) ? CAP_MAX : cap_ff;
   assign is_put   = (req_ff.mode == MODE_PUT);
   assign do_hit   = found_ff;
   assign do_evict = !found_ff && is_put && (cap_eff != '0) && (occ_ff >= cap_eff) && any_ff;
   assign do_fill  = !found_ff && is_put && (cap_eff != '0) && !do_evict && free_ff;
   assign slot     = do_evict ? vic_idx_ff : free_idx_ff;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // request capture and scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         idx_ff   <= '0;
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + 1'b1;
         if (cur_match && !found_ff) begin
            found_ff      <= 1'b1;
            found_idx_ff  <= idx_ff;
            found_data_ff <= data_ff[idx_ff];
            found_rank_ff <= rank_ff[idx_ff];
         end
         if (cur_better) begin
            any_ff       <= 1'b1;
            vic_idx_ff   <= idx_ff;
            vic_key_ff   <= key_ff[idx_ff];
            vic_count_ff <= count_ff[idx_ff];
            vic_rank_ff  <= rank_ff[idx_ff];
         end
         if (!cur_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
   end

   // control part of the store: valid, count, rank, occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            count_ff[i] <= '0;
            rank_ff[i]  <= '0;
         end
      end else if (cmd.commit) begin
         if (do_fill) occ_ff <= occ_ff + 1'b1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (do_hit) begin
               if (IDX_BITS'(i) == found_idx_ff) begin
                  if (count_ff[i] != COUNT_MAX) count_ff[i] <= count_ff[i] + 1'b1;
                  rank_ff[i] <= '0;
               end else if (valid_ff[i] && (rank_ff[i] < found_rank_ff)) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end else if (do_evict || do_fill) begin
               if (IDX_BITS'(i) == slot) begin
                  valid_ff[i] <= 1'b1;
                  count_ff[i] <= COUNT_ONE;
                  rank_ff[i]  <= '0;
               end else if (valid_ff[i]) begin
                  // older than the victim moves up one, then everyone ages one
                  if (do_evict && (rank_ff[i] > vic_rank_ff)) rank_ff[i] <= rank_ff[i];
                  else rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   // key and value store
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (do_hit && is_put) data_ff[found_idx_ff] <= req_ff.value;
         if (do_evict || do_fill) begin
            key_ff[slot]  <= req_ff.key;
            data_ff[slot] <= req_ff.value;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.hit         <= found_ff;
         rsp_ff.read_value  <= (found_ff && !is_put) ? found_data_ff : '0;
         rsp_ff.evicted     <= do_evict;
         rsp_ff.evicted_key <= do_evict ? vic_key_ff : '0;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   // occupancy never exceeds the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP_MAX)
      else $error("occupancy above entry count");

   // eviction keeps occupancy unchanged
   a_evict_occ: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_evict) |=> (occ_ff == $past(occ_ff)))
      else $error("eviction changed occupancy");

   // hit and insert never happen together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(do_hit && (do_evict || do_fill)))
      else $error("hit and insert in one commit");
`endif

endmodule

### hdl/lfu_cache_with_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak: 16-entry LFU key/value store, LRU tie-break
// Each item is accepted, scanned one step per entry over all 16 entries, then
// committed: the store is updated and the result register loaded when free.
// The next item is accepted after the commit, even while the result waits to
// be taken. Capacity is written via csr_we/csr_wdata; the user must do so
// only while idle (not enforced); over 16 acts as 16 and 0 disables insertion.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak
   import lfu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // entry store and update logic
   lfu_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule
